@@ rtl/fpbp_pkg.sv @@
// shared types and constants of the framed packet byte parser
`timescale 1ns / 1ps

package fpbp_pkg;

    // parser phases, also given out as parser_state
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_HEAD   = 3'd1,
        PH_LEN    = 3'd2,
        PH_SEQ    = 3'd3,
        PH_BODY   = 3'd4,
        PH_DONE   = 3'd5,
        PH_CK_OK  = 3'd6,
        PH_CK_BAD = 3'd7
    } phase_t;

    // frame status codes
    localparam logic [1:0] STATUS_NONE = 2'd0;
    localparam logic [1:0] STATUS_GOOD = 2'd1;
    localparam logic [1:0] STATUS_BAD  = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_HEAD        = 3'd0;
    localparam logic [2:0] REG_TAIL        = 3'd1;
    localparam logic [2:0] REG_ENTRY_COUNT = 3'd2;
    localparam int         REG_TABLE_BASE  = 3;

    localparam int CFG_INDEX_W = 3;

    // scalar configuration seen by the parser
    typedef struct packed {
        logic [7:0] head_byte;
        logic [7:0] tail_byte;
        logic [2:0] entry_count;
    } cfg_t;

    // one result item
    typedef struct packed {
        logic [1:0]  frame_status;
        logic [2:0]  parser_state;
        logic [7:0]  payload_index;
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [7:0]  frame_length;
        logic [7:0]  function_code_out;
        logic [7:0]  next_sequence;
        logic [7:0]  checksum_value;
        logic [15:0] good_frame_count;
        logic        header_error;
    } result_t;

endpackage

@@ rtl/fpbp_cfg.sv @@
// configuration register bank: head, tail, entry count and code table
`timescale 1ns / 1ps

module fpbp_cfg
    import fpbp_pkg::*;
#(
    parameter int TABLE_ENTRIES = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                wr_en,
    input  logic [CFG_INDEX_W-1:0]              wr_index,
    input  logic [15:0]                         wr_data,
    output cfg_t                                cfg,
    output logic [TABLE_ENTRIES-1:0][15:0]      entries
);

    cfg_t                           cfg_reg;
    logic [TABLE_ENTRIES-1:0][15:0] entries_reg;

    // register writes, reset to the documented defaults
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.head_byte   <= 8'd170;
            cfg_reg.tail_byte   <= 8'd85;
            cfg_reg.entry_count <= 3'd0;
            entries_reg         <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_HEAD:        cfg_reg.head_byte   <= wr_data[7:0];
                REG_TAIL:        cfg_reg.tail_byte   <= wr_data[7:0];
                REG_ENTRY_COUNT: cfg_reg.entry_count <= wr_data[2:0];
                default:
                begin
                    for (int k = 0; k < TABLE_ENTRIES; k++)
                    begin
                        if (wr_index == CFG_INDEX_W'(REG_TABLE_BASE + k))
                        begin
                            entries_reg[k] <= wr_data;
                        end
                    end
                end
            endcase
        end
    end

    assign cfg     = cfg_reg;
    assign entries = entries_reg;

endmodule

@@ rtl/fpbp_core.sv @@
// parser state registers and the per-byte next-state and result logic
`timescale 1ns / 1ps

module fpbp_core
    import fpbp_pkg::*;
#(
    parameter int TABLE_ENTRIES = 4,
    parameter int MAX_PAYLOAD   = 255
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           take,
    input  logic [7:0]                     rx_byte,
    input  cfg_t                           cfg,
    input  logic [TABLE_ENTRIES-1:0][15:0] entries,
    output result_t                        result
);

    phase_t      phase_reg,    phase_next;
    logic [7:0]  len_reg,      len_next;
    logic [7:0]  seq_reg,      seq_next;
    logic [7:0]  code_reg,     code_next;
    logic [7:0]  sum_reg,      sum_next;
    logic [7:0]  count_reg,    count_next;
    logic [7:0]  ck_reg,       ck_next;
    logic [7:0]  last_seq_reg, last_seq_next;
    logic [15:0] good_reg,     good_next;

    logic        match;
    logic [1:0]  status;
    logic        perr;
    logic        pvalid;

    // parallel compare of code and length against the enabled entries
    always_comb
    begin
        match = 1'b0;
        for (int k = 0; k < TABLE_ENTRIES; k++)
        begin
            if (3'(k) < cfg.entry_count && entries[k][15:8] == rx_byte &&
                entries[k][7:0] == len_reg)
            begin
                match = 1'b1;
            end
        end
    end

    // next state for one byte
    always_comb
    begin
        phase_next    = phase_reg;
        len_next      = len_reg;
        seq_next      = seq_reg;
        code_next     = code_reg;
        sum_next      = sum_reg;
        count_next    = count_reg;
        ck_next       = ck_reg;
        last_seq_next = last_seq_reg;
        good_next     = good_reg;
        status        = STATUS_NONE;
        perr          = 1'b0;
        pvalid        = 1'b0;
        case (phase_reg)
            PH_IDLE:
            begin
                if (rx_byte == cfg.head_byte)
                begin
                    phase_next = PH_HEAD;
                    len_next   = 8'd0;
                    count_next = 8'd0;
                    sum_next   = 8'd0;
                end
            end
            PH_HEAD:
            begin
                if (rx_byte > 8'(MAX_PAYLOAD))
                begin
                    perr       = 1'b1;
                    phase_next = PH_IDLE;
                end
                else
                begin
                    len_next   = rx_byte;
                    count_next = 8'd0;
                    sum_next   = sum_reg + rx_byte;
                    phase_next = PH_LEN;
                end
            end
            PH_LEN:
            begin
                seq_next   = rx_byte;
                sum_next   = sum_reg + rx_byte;
                phase_next = PH_SEQ;
            end
            PH_SEQ:
            begin
                if (!match)
                begin
                    perr       = 1'b1;
                    phase_next = PH_IDLE;
                end
                else
                begin
                    code_next  = rx_byte;
                    sum_next   = sum_reg + rx_byte;
                    phase_next = (len_reg != 8'd0) ? PH_BODY : PH_DONE;
                end
            end
            PH_BODY:
            begin
                count_next = count_reg + 8'd1;
                sum_next   = sum_reg + rx_byte;
                pvalid     = 1'b1;
                if (count_next == len_reg)
                begin
                    phase_next = PH_DONE;
                end
            end
            PH_DONE:
            begin
                ck_next    = rx_byte;
                phase_next = (rx_byte != sum_reg) ? PH_CK_BAD : PH_CK_OK;
            end
            PH_CK_OK, PH_CK_BAD:
            begin
                if (phase_reg == PH_CK_OK && rx_byte == cfg.tail_byte)
                begin
                    status        = STATUS_GOOD;
                    last_seq_next = seq_reg;
                    good_next     = good_reg + 16'd1;
                end
                else
                begin
                    status = STATUS_BAD;
                end
                phase_next = PH_IDLE;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // result item built from the updated state
    always_comb
    begin
        result.frame_status      = status;
        result.parser_state      = phase_next;
        result.payload_index     = count_next;
        result.payload_valid     = pvalid;
        result.payload_byte      = pvalid ? rx_byte : 8'd0;
        result.frame_length      = len_next;
        result.function_code_out = code_next;
        result.next_sequence     = last_seq_next + 8'd1;
        result.checksum_value    = (status == STATUS_BAD) ? ck_next : sum_next;
        result.good_frame_count  = good_next;
        result.header_error      = perr;
    end

    // state update on every accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            len_reg      <= '0;
            seq_reg      <= '0;
            code_reg     <= '0;
            sum_reg      <= '0;
            count_reg    <= '0;
            ck_reg       <= '0;
            last_seq_reg <= '0;
            good_reg     <= '0;
        end
        else if (take)
        begin
            phase_reg    <= phase_next;
            len_reg      <= len_next;
            seq_reg      <= seq_next;
            code_reg     <= code_next;
            sum_reg      <= sum_next;
            count_reg    <= count_next;
            ck_reg       <= ck_next;
            last_seq_reg <= last_seq_next;
            good_reg     <= good_next;
        end
    end

endmodule

@@ rtl/framed_packet_byte_parser.sv @@
// framed packet byte parser: top level with handshake and result register
//
// Input channel: in_valid / in_stall with rx_byte, one received byte per item.
// Output channel: out_valid / out_stall with one result item per byte: frame
// status, parser state, payload byte and index, frame fields, checksum, the
// next expected sequence and the good frame count.
// Config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; index 0
// head byte, 1 tail byte, 2 entry count, 3 and up the code/length table.
// cfg_ready is always high; write only while no item is in flight.
// A result is valid in the cycle after its byte is accepted.
// Throughput: one byte per cycle while in_stall is low; the parse step and the
// TABLE_ENTRIES-entry table compare sit between the input handshake and the result register.
// Stall: in_stall rises only while a result is held and out_stall is high,
// so a byte can be taken in the same cycle the held result leaves.
// Reset: the parser returns to idle, counters clear and the registers take
// head 170, tail 85, no table entries enabled.
`timescale 1ns / 1ps

module framed_packet_byte_parser
    import fpbp_pkg::*;
#(
    parameter int TABLE_ENTRIES = 4,
    parameter int MAX_PAYLOAD   = 255
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [7:0]             rx_byte,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [1:0]             frame_status,
    output logic [2:0]             parser_state,
    output logic [7:0]             payload_index,
    output logic                   payload_valid,
    output logic [7:0]             payload_byte,
    output logic [7:0]             frame_length,
    output logic [7:0]             function_code_out,
    output logic [7:0]             next_sequence,
    output logic [7:0]             checksum_value,
    output logic [15:0]            good_frame_count,
    output logic                   header_error,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [15:0]            cfg_data
);

    cfg_t                           cfg;
    logic [TABLE_ENTRIES-1:0][15:0] entries;
    result_t                        result;
    result_t                        result_reg;
    logic                           out_valid_reg;
    logic                           take;

    // config writes are always taken
    assign cfg_ready = 1'b1;

    // a byte is taken unless a held result is blocked
    assign in_stall = out_valid_reg && out_stall;
    assign take     = in_valid && !in_stall;

    fpbp_cfg #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (cfg_valid && cfg_ready),
        .wr_index(cfg_index),
        .wr_data (cfg_data),
        .cfg     (cfg),
        .entries (entries)
    );

    fpbp_core #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .MAX_PAYLOAD  (MAX_PAYLOAD)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .take   (take),
        .rx_byte(rx_byte),
        .cfg    (cfg),
        .entries(entries),
        .result (result)
    );

    // result register and its valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result_reg <= result;
        end
    end

    assign out_valid         = out_valid_reg;
    assign frame_status      = result_reg.frame_status;
    assign parser_state      = result_reg.parser_state;
    assign payload_index     = result_reg.payload_index;
    assign payload_valid     = result_reg.payload_valid;
    assign payload_byte      = result_reg.payload_byte;
    assign frame_length      = result_reg.frame_length;
    assign function_code_out = result_reg.function_code_out;
    assign next_sequence     = result_reg.next_sequence;
    assign checksum_value    = result_reg.checksum_value;
    assign good_frame_count  = result_reg.good_frame_count;
    assign header_error      = result_reg.header_error;

`ifndef ASSERT_OFF
    // a header error always drops back to idle
    a_perr_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && header_error) |-> (parser_state == PH_IDLE))
        else $error("header error without return to idle");

    // a finished frame always drops back to idle
    a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && frame_status != STATUS_NONE) |-> (parser_state == PH_IDLE))
        else $error("frame end without return to idle");

    // payload bytes only while in the body or just finishing it
    a_payload_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && payload_valid) |->
        (parser_state == PH_BODY || parser_state == PH_DONE))
        else $error("payload byte outside the frame body");

    // the count of a good frame reaches the result register
    a_good_count: assert property (@(posedge clk) disable iff (!rst_n)
        (take && result.frame_status == STATUS_GOOD) |=>
        (good_frame_count == $past(result.good_frame_count)))
        else $error("good frame count not registered");

    // stall on the input only while a result is held
    a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no result held");
`endif

endmodule
